FILE: design/bde_pkg.sv
`default_nettype none
package bde_pkg;

	// register indexes on the configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_HIGH     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EVENT_MODE      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_INTERVAL  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_SAMPLES = 2'd3;

	// event kinds
	localparam logic [1:0] KIND_PRESS    = 2'd0;
	localparam logic [1:0] KIND_RELEASE  = 2'd1;
	localparam logic [1:0] KIND_DURATION = 2'd2;

	localparam logic [15:0] DROP_MAX = 16'hFFFF;

	typedef struct packed {
		logic pin_level;
		logic sink_room;
	} tick_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [31:0] event_time;
		logic [15:0] dropped_presses;
	} evt_t;

	typedef struct packed {
		logic        active_high;
		logic        event_mode;
		logic [15:0] check_interval;
		logic [7:0]  release_samples;
	} cfg_t;

	typedef struct packed {
		logic tracking;
		logic press_lost;
	} status_t;

endpackage
`default_nettype wire

FILE: design/bde_core.sv
`default_nettype none
module bde_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bde_pkg::cfg_t   cfg,
	input  wire logic            step,
	input  wire bde_pkg::tick_t  item,
	output logic                 res_valid,
	output bde_pkg::evt_t        res,
	output bde_pkg::status_t     status
);

	logic [31:0] tick_count_q;
	logic        tracking_q;
	logic        last_level_q;
	logic [15:0] interval_count_q;
	logic [7:0]  inactive_run_q;
	logic [31:0] press_stamp_q;
	logic        press_lost_q;
	logic [15:0] drop_total_q;

	logic        tracking_d;
	logic [15:0] interval_count_d;
	logic [7:0]  inactive_run_d;
	logic [31:0] press_stamp_d;
	logic        press_lost_d;
	logic [15:0] drop_total_d;
	logic        active;
	logic        was_active;
	logic [15:0] interval_inc;
	logic [7:0]  run_next;

	assign active       = (item.pin_level == cfg.active_high);
	assign was_active   = (last_level_q == cfg.active_high);
	assign interval_inc = interval_count_q + 16'd1;
	assign run_next     = active ? 8'd0 : inactive_run_q + 8'd1;

	// one tick of the debounce state
	always_comb begin
		tracking_d       = tracking_q;
		interval_count_d = interval_count_q;
		inactive_run_d   = inactive_run_q;
		press_stamp_d    = press_stamp_q;
		press_lost_d     = press_lost_q;
		drop_total_d     = drop_total_q;
		res_valid        = 1'b0;
		res.event_kind   = bde_pkg::KIND_PRESS;
		res.event_time   = tick_count_q;
		if (!tracking_q) begin
			if (active && !was_active) begin
				tracking_d       = 1'b1;
				press_stamp_d    = tick_count_q;
				interval_count_d = 16'd0;
				inactive_run_d   = 8'd0;
				press_lost_d     = 1'b0;
				if (cfg.event_mode) begin
					if (item.sink_room) begin
						res_valid = 1'b1;
					end else begin
						press_lost_d = 1'b1;
						if (drop_total_q != bde_pkg::DROP_MAX) begin
							drop_total_d = drop_total_q + 16'd1;
						end
					end
				end
			end
		end else begin
			interval_count_d = interval_inc;
			if (interval_inc == cfg.check_interval) begin
				interval_count_d = 16'd0;
				inactive_run_d   = run_next;
				if (!active && run_next == cfg.release_samples) begin
					tracking_d     = 1'b0;
					inactive_run_d = 8'd0;
					press_lost_d   = 1'b0;
					if (cfg.event_mode) begin
						res_valid      = !press_lost_q;
						res.event_kind = bde_pkg::KIND_RELEASE;
					end else begin
						res_valid      = 1'b1;
						res.event_kind = bde_pkg::KIND_DURATION;
						res.event_time = tick_count_q - press_stamp_q;
					end
				end
			end
		end
		res.dropped_presses = drop_total_d;
	end

	// state registers, advanced once per consumed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q     <= 32'd0;
			tracking_q       <= 1'b0;
			last_level_q     <= 1'b1;
			interval_count_q <= 16'd0;
			inactive_run_q   <= 8'd0;
			press_stamp_q    <= 32'd0;
			press_lost_q     <= 1'b0;
			drop_total_q     <= 16'd0;
		end else if (step) begin
			tick_count_q     <= tick_count_q + 32'd1;
			tracking_q       <= tracking_d;
			last_level_q     <= item.pin_level;
			interval_count_q <= interval_count_d;
			inactive_run_q   <= inactive_run_d;
			press_stamp_q    <= press_stamp_d;
			press_lost_q     <= press_lost_d;
			drop_total_q     <= drop_total_d;
		end
	end

	assign status.tracking   = tracking_q;
	assign status.press_lost = press_lost_q;

endmodule
`default_nettype wire

FILE: design/bde_out_reg.sv
`default_nettype none
module bde_out_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire bde_pkg::evt_t  data,
	output logic                room,
	output logic                evt_valid,
	input  wire logic           evt_stall,
	output bde_pkg::evt_t       evt_data
);

	logic          valid_s2;
	bde_pkg::evt_t data_s2;

	// register can take a new beat when empty or being drained
	assign room = !valid_s2 || !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (room) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			data_s2 <= data;
		end
	end

	assign evt_valid = valid_s2;
	assign evt_data  = data_s2;

endmodule
`default_nettype wire

FILE: design/button_debounce_event_gen_top.sv
`default_nettype none
// Push-button debouncer. Each tick beat carries one pin sample and the sink's
// room flag; the block answers with zero or one event beat (press, release
// or held duration) per tick. Ticks are taken one per clock: a tick sits in
// an input register, the debounce state is updated in one pass of logic,
// and an event lands in an output register; the only stall comes from a
// stalled event output with its register full. The user must write the
// configuration via cfg_we/cfg_index/cfg_data only while idle (not enforced).
module button_debounce_event_gen_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bde_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [bde_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               tick_valid,
	output logic                                    tick_stall,
	input  wire bde_pkg::tick_t                     tick_data,
	output logic                                    evt_valid,
	input  wire logic                               evt_stall,
	output bde_pkg::evt_t                           evt_data
);

	bde_pkg::cfg_t    cfg_q;
	logic             valid_s1;
	bde_pkg::tick_t   item_s1;
	logic             room;
	logic             step;
	logic             res_valid;
	bde_pkg::evt_t    res;
	bde_pkg::status_t status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high     <= 1'b0;
			cfg_q.event_mode      <= 1'b1;
			cfg_q.check_interval  <= 16'd10;
			cfg_q.release_samples <= 8'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bde_pkg::CFG_ACTIVE_HIGH:     cfg_q.active_high     <= cfg_data[0];
				bde_pkg::CFG_EVENT_MODE:      cfg_q.event_mode      <= cfg_data[0];
				bde_pkg::CFG_CHECK_INTERVAL:  cfg_q.check_interval  <= cfg_data;
				bde_pkg::CFG_RELEASE_SAMPLES: cfg_q.release_samples <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	assign step       = valid_s1 && room;
	assign tick_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			item_s1 <= tick_data;
		end
	end

	bde_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	bde_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.data      (res),
		.room      (room),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_data  (evt_data)
	);

	// input only backs up behind a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> (valid_s1 && evt_valid && evt_stall))
		else $error("tick stalled without a blocked event");

	// a delivered press starts tracking
	a_press_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res.event_kind == bde_pkg::KIND_PRESS)
		|=> (status.tracking && !status.press_lost))
		else $error("press event without tracking");

	// duration reports only come out in duration mode
	a_duration_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res.event_kind == bde_pkg::KIND_DURATION)
		|-> !cfg_q.event_mode)
		else $error("duration report in event mode");

	// any event ends or starts a press
	a_event_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid) |=> (status.tracking != $past(status.tracking)))
		else $error("event without tracking change");

endmodule
`default_nettype wire
